[hdl/bts_pkg.sv]
// Buzzer tone sequencer package: beat types, controller/datapath command
// and status structs, state and action enums, and the effect tone table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_INC  = 32'd1013904223;
    localparam logic [8:0]  LCG_MASK = 9'h1FF;
    localparam logic [8:0]  GL_MOD   = 9'd500;
    localparam logic [10:0] GL_BASE  = 11'd100;
    localparam logic [10:0] STEP_HI  = 11'd900;
    localparam logic [10:0] STEP_LO  = 11'd800;

    localparam logic [2:0] EFF_STEP     = 3'd0;
    localparam logic [2:0] EFF_SHARD    = 3'd1;
    localparam logic [2:0] EFF_DEATH    = 3'd2;
    localparam logic [2:0] EFF_ANCHOR   = 3'd3;
    localparam logic [2:0] EFF_WIN      = 3'd4;
    localparam logic [2:0] EFF_DISSOLVE = 3'd5;
    localparam logic [2:0] EFF_GLITCH   = 3'd6;
    localparam logic [2:0] EFF_EXIT     = 3'd7;

    typedef enum logic [1:0] {
        ACT_HOLD    = 2'd0,
        ACT_SILENCE = 2'd1,
        ACT_START   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PLAY
    } t_state;

    typedef struct packed {
        logic        func;
        logic [3:0]  effect;
        logic [31:0] frame_count;
    } t_in_beat;

    typedef struct packed {
        t_action     action;
        logic [10:0] tone_freq;
    } t_out_beat;

    typedef struct packed {
        logic [10:0] freq;
        logic [2:0]  frames;
    } t_tone;

    typedef struct packed {
        logic load;
        logic tick;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic is_play;
        logic effect_ok;
        logic last_tone;
    } t_sts;

    function automatic logic [2:0] eff_len(input logic [2:0] eff);
        logic [2:0] n;
        unique case (eff)
            EFF_SHARD, EFF_DEATH: n = 3'd5;
            EFF_ANCHOR:           n = 3'd3;
            EFF_WIN:              n = 3'd7;
            default:              n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic t_tone mk(input int f, input int d);
        t_tone t;
        t.freq   = 11'(f);
        t.frames = 3'(d);
        return t;
    endfunction

    // fixed tone lists; step and glitch frequencies are patched in the datapath
    function automatic t_tone tone_rom(input logic [2:0] eff, input logic [2:0] idx);
        t_tone t;
        t = mk(0, 1);
        unique case (eff)
            EFF_SHARD: begin
                unique case (idx)
                    3'd0:    t = mk(660, 1);
                    3'd2:    t = mk(880, 1);
                    3'd4:    t = mk(1320, 2);
                    default: t = mk(0, 1);
                endcase
            end
            EFF_DEATH: begin
                unique case (idx)
                    3'd0:    t = mk(400, 2);
                    3'd2:    t = mk(220, 2);
                    3'd4:    t = mk(110, 3);
                    default: t = mk(0, 1);
                endcase
            end
            EFF_ANCHOR: begin
                unique case (idx)
                    3'd1:    t = mk(554, 1);
                    default: t = mk(440, 1);
                endcase
            end
            EFF_WIN: begin
                unique case (idx)
                    3'd0:    t = mk(523, 3);
                    3'd2:    t = mk(659, 3);
                    3'd4:    t = mk(784, 3);
                    3'd6:    t = mk(1047, 4);
                    default: t = mk(0, 1);
                endcase
            end
            EFF_DISSOLVE: t = mk(200, 1);
            EFF_EXIT:     t = mk(880, 1);
            default:      t = mk(0, 1);
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[hdl/buzzer_tone_sequencer_unit.sv]
// Buzzer tone sequencer top level: controller plus datapath.
// Depends on bts_pkg, bts_ctrl and bts_dpath.
//
// Usage:
//   Input: drive i_in and raise i_start; the beat is taken on a rising edge
//   with i_start high and o_busy low. func = 1 plays an effect, func = 0 is
//   a frame tick.
//   Output: every tick yields one result beat on o_result, flagged by
//   o_strobe for exactly one cycle; play requests yield nothing.
//   Tick result: decoded in ST_DECODE, then registered into o_result and
//   o_strobe. No new beat is taken while o_busy is high. A play writes
//   its n tones (n being the effect's tone count, 1 to 7) in ST_PLAY, one
//   ring write per cycle, dropped on a full ring; ids 8 to 15 skip ST_PLAY.
//   Reset: synchronous, active low; empties the tone ring and clears the
//   timer. Ring contents are not cleared.
//   The receiver has no back-pressure: o_strobe beats must be taken as they
//   come.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_tone_sequencer_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire bts_pkg::t_in_beat i_in,
    output logic                   o_busy,
    output bts_pkg::t_out_beat     o_result,
    output logic                   o_strobe
);
    import bts_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    bts_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_in.func) |=> ##1 o_strobe)
        else $error("tick beat without result");

    a_play_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.func) |=> !o_strobe ##1 !o_strobe)
        else $error("play request produced a result");

    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.action != ACT_START) |-> (o_result.tone_freq == '0))
        else $error("nonzero frequency without tone start");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.tick, cmd.push}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire

[hdl/bts_ctrl.sv]
// Buzzer tone sequencer controller: accepts beats and sequences tick
// handling and effect expansion. Depends on bts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire bts_pkg::t_sts i_sts,
    output bts_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import bts_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_sts.is_play) begin
                    o_cmd.tick = 1'b1;
                    n_state    = ST_IDLE;
                end else if (i_sts.effect_ok) begin
                    n_state = ST_PLAY;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PLAY: begin
                o_cmd.push = 1'b1;
                if (i_sts.last_tone) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

[hdl/bts_dpath.sv]
// Buzzer tone sequencer datapath: input capture, tone ring, timer, effect
// tone generation and registered result. Depends on bts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bts_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bts_pkg::t_in_beat i_in,
    input  wire bts_pkg::t_cmd     i_cmd,
    output bts_pkg::t_sts          o_sts,
    output bts_pkg::t_out_beat     o_result,
    output logic                   o_strobe
);
    import bts_pkg::*;

    t_in_beat          r_in;
    logic [2:0]        r_idx;
    t_tone             r_queue [QUEUE_DEPTH];
    t_tone             r_pop;
    logic [QPTR_W-1:0] r_head, r_tail;
    logic [2:0]        r_timer;
    t_out_beat         r_result;
    logic              r_strobe;

    logic [QPTR_W-1:0] tail_nxt, head_nxt;
    logic [12:0]       gl_prod;
    logic [8:0]        gl_r, gl_m;
    logic [10:0]       gl_freq;
    t_tone             push_tone;

    function automatic logic [QPTR_W-1:0] ring_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign tail_nxt = ring_next(r_tail);
    assign head_nxt = ring_next(r_head);

    // only the low nine bits of the LCG output matter
    assign gl_prod = {4'b0000, r_in.frame_count[8:0]} * {9'b0_0000_0000, LCG_MUL[3:0]};
    assign gl_r    = gl_prod[8:0] + LCG_INC[8:0];
    assign gl_m    = (gl_r >= GL_MOD) ? gl_r - GL_MOD : gl_r & LCG_MASK;
    assign gl_freq = GL_BASE + {2'b00, gl_m};

    always_comb begin
        push_tone = tone_rom(r_in.effect[2:0], r_idx);
        if (r_in.effect[2:0] == EFF_STEP) begin
            push_tone.freq = r_in.frame_count[3] ? STEP_HI : STEP_LO;
        end else if (r_in.effect[2:0] == EFF_GLITCH) begin
            push_tone.freq = gl_freq;
        end
    end

    assign o_sts.is_play   = r_in.func;
    assign o_sts.effect_ok = ~r_in.effect[3];
    assign o_sts.last_tone = (r_idx == eff_len(r_in.effect[2:0]) - 3'd1);

    // head slot is read on every edge; ring and head are settled by the accept edge
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
        if (i_cmd.push && (tail_nxt != r_head)) begin
            r_queue[r_tail] <= push_tone;
        end
        r_pop    <= r_queue[r_head];
        r_result <= '0;
        if (i_cmd.tick) begin
            if (r_timer != 3'd0) begin
                r_result.action <= ACT_HOLD;
            end else if (r_head == r_tail) begin
                r_result.action <= ACT_SILENCE;
            end else begin
                r_result.action    <= (r_pop.freq != '0) ? ACT_START : ACT_SILENCE;
                r_result.tone_freq <= r_pop.freq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_timer  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.tick;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.push) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_cmd.push && (tail_nxt != r_head)) begin
                r_tail <= tail_nxt;
            end
            if (i_cmd.tick) begin
                if (r_timer != 3'd0) begin
                    r_timer <= r_timer - 3'd1;
                end else if (r_head != r_tail) begin
                    r_timer <= r_pop.frames;
                    r_head  <= head_nxt;
                end
            end
        end
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

[tb/sv/tb_buzzer_tone_sequencer_unit.sv]
// Self-checking testbench for buzzer_tone_sequencer_unit: directed effect,
// empty-ring and full-ring tests, then random plays and ticks checked beat by beat.
// Depends on bts_pkg and the buzzer_tone_sequencer_unit RTL.
`timescale 1ns / 1ps

module tb_buzzer_tone_sequencer_unit;

    import bts_pkg::*;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_PLAY = 1'b1;

    localparam int RING_SLOTS   = 16;
    localparam int RANDOM_ITEMS = 1950;
    localparam int BLOCK_ITEMS  = 50;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_beat  i_in;
    logic      o_busy;
    t_out_beat o_result;
    logic      o_strobe;

    buzzer_tone_sequencer_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_in     (i_in),
        .o_busy   (o_busy),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    // tone sequencer shadow state
    logic [10:0] ring_freq   [RING_SLOTS];
    logic [2:0]  ring_frames [RING_SLOTS];
    logic [3:0]  ring_head;
    logic [3:0]  ring_tail;
    logic [2:0]  frames_left;

    t_out_beat tick_results_due[$];

    int  err_count;
    int  beats_sent;
    int  plays_sent;
    int  ticks_sent;
    int  results_checked;
    int  tones_dropped;
    int  idle_cycles;
    bit  gaps_enabled;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    task automatic queue_tone(input int freq, input int frames);
        logic [3:0] nxt;
        nxt = ring_tail + 4'd1;
        if (nxt == ring_head) begin
            tones_dropped++;
        end else begin
            ring_freq[ring_tail]   = 11'(freq);
            ring_frames[ring_tail] = 3'(frames);
            ring_tail              = nxt;
        end
    endtask

    task automatic expand_effect(input logic [3:0] effect, input logic [31:0] frame);
        logic [31:0] lcg;
        case (effect)
            {1'b0, EFF_STEP}: begin
                queue_tone(frame[3] ? int'(STEP_HI) : int'(STEP_LO), 1);
            end
            {1'b0, EFF_SHARD}: begin
                queue_tone(660, 1);  queue_tone(0, 1);
                queue_tone(880, 1);  queue_tone(0, 1);
                queue_tone(1320, 2);
            end
            {1'b0, EFF_DEATH}: begin
                queue_tone(400, 2);  queue_tone(0, 1);
                queue_tone(220, 2);  queue_tone(0, 1);
                queue_tone(110, 3);
            end
            {1'b0, EFF_ANCHOR}: begin
                queue_tone(440, 1);  queue_tone(554, 1);  queue_tone(440, 1);
            end
            {1'b0, EFF_WIN}: begin
                queue_tone(523, 3);  queue_tone(0, 1);
                queue_tone(659, 3);  queue_tone(0, 1);
                queue_tone(784, 3);  queue_tone(0, 1);
                queue_tone(1047, 4);
            end
            {1'b0, EFF_DISSOLVE}: begin
                queue_tone(200, 1);
            end
            {1'b0, EFF_GLITCH}: begin
                lcg = frame * LCG_MUL + LCG_INC;
                queue_tone(int'(GL_BASE) + int'((lcg[8:0] & LCG_MASK) % GL_MOD), 1);
            end
            {1'b0, EFF_EXIT}: begin
                queue_tone(880, 1);
            end
            default: begin
            end
        endcase
    endtask

    task automatic apply_beat(input t_in_beat b);
        t_out_beat res;
        if (b.func == FUNC_PLAY) begin
            expand_effect(b.effect, b.frame_count);
        end else begin
            res.tone_freq = '0;
            if (frames_left != 3'd0) begin
                frames_left = frames_left - 3'd1;
                res.action  = ACT_HOLD;
            end else if (ring_head == ring_tail) begin
                res.action = ACT_SILENCE;
            end else begin
                res.tone_freq = ring_freq[ring_head];
                frames_left   = ring_frames[ring_head];
                ring_head     = ring_head + 4'd1;
                res.action    = (res.tone_freq != '0) ? ACT_START : ACT_SILENCE;
            end
            tick_results_due.push_back(res);
        end
    endtask

    // ---------------- driver ----------------

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!gaps_enabled || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance with
    // start still high so back-to-back beats need no bubble
    task automatic drive_beat(input logic func, input logic [3:0] effect,
                              input logic [31:0] frame);
        t_in_beat b;
        int gap;
        b.func        = func;
        b.effect      = effect;
        b.frame_count = frame;
        gap = pick_gap();
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in    = b;
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        apply_beat(b);
        beats_sent++;
        if (func == FUNC_PLAY) plays_sent++;
        else ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        drive_beat(FUNC_TICK, 4'($urandom_range(0, 15)), $urandom);
    endtask

    task automatic send_play(input logic [3:0] effect, input logic [31:0] frame);
        drive_beat(FUNC_PLAY, effect, frame);
    endtask

    task automatic play_out_ring();
        while (ring_head != ring_tail || frames_left != 3'd0) send_tick();
        send_tick();
    endtask

    task automatic settle();
        i_start = 1'b0;
        while (tick_results_due.size() != 0) @(negedge i_clk);
    endtask

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin : check_result
        t_out_beat want;
        if (i_rst_n && o_strobe) begin
            if (tick_results_due.size() == 0) begin
                $error("result beat with no tick outstanding: action=%0d tone_freq=%0d",
                       o_result.action, o_result.tone_freq);
                err_count++;
            end else begin
                want = tick_results_due.pop_front();
                results_checked++;
                if (o_result.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_result.action);
                    err_count++;
                end
                if (o_result.tone_freq !== want.tone_freq) begin
                    $error("tone_freq: expected %0d, got %0d",
                           want.tone_freq, o_result.tone_freq);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_empty_ring();
        drive_beat(FUNC_TICK, 4'd0, 32'd0);
        drive_beat(FUNC_TICK, 4'hF, 32'hFFFF_FFFF);
        settle();
    endtask

    task automatic test_unknown_effects();
        send_play(4'd8, 32'hFFFF_FFFF);
        send_play(4'd15, 32'd0);
        send_tick();
        settle();
    endtask

    task automatic test_effect_tones();
        send_play({1'b0, EFF_STEP}, 32'd0);
        send_play({1'b0, EFF_STEP}, 32'd8);
        play_out_ring();
        send_play({1'b0, EFF_GLITCH}, 32'd0);
        send_play({1'b0, EFF_GLITCH}, 32'hFFFF_FFFF);
        play_out_ring();
        for (int e = 1; e < 8; e++) begin
            if (3'(e) != EFF_GLITCH) begin
                send_play({1'b0, 3'(e)}, $urandom);
                play_out_ring();
            end
        end
        settle();
    endtask

    task automatic test_ring_full();
        send_play({1'b0, EFF_WIN}, 32'd0);
        send_play({1'b0, EFF_WIN}, 32'd0);
        send_play({1'b0, EFF_WIN}, 32'd0);
        send_tick();
        send_play({1'b0, EFF_ANCHOR}, 32'd0);
        play_out_ring();
        settle();
    endtask

    task automatic test_random_traffic();
        int counted;
        int play_pct;
        logic [3:0] effect;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            play_pct     = $urandom_range(5, 70);
            gaps_enabled = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                if ($urandom_range(0, 99) < play_pct) begin
                    if ($urandom_range(0, 9) == 0) begin
                        effect = 4'($urandom_range(8, 15));
                    end else begin
                        effect = 4'($urandom_range(0, 7));
                        counted++;
                    end
                    send_play(effect, $urandom);
                end else begin
                    send_tick();
                    counted++;
                end
            end
        end
        gaps_enabled = 1'b1;
        settle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_in            = '0;
        ring_head       = '0;
        ring_tail       = '0;
        frames_left     = '0;
        err_count       = 0;
        beats_sent      = 0;
        plays_sent      = 0;
        ticks_sent      = 0;
        results_checked = 0;
        tones_dropped   = 0;
        idle_cycles     = 0;
        gaps_enabled    = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_ring();
        test_unknown_effects();
        test_effect_tones();
        test_ring_full();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tick_results_due.size() != 0) begin
            $error("%0d tick results never arrived", tick_results_due.size());
            err_count++;
        end
        $display("Run covered %0d beats (%0d plays, %0d ticks), %0d results checked,",
                 beats_sent, plays_sent, ticks_sent, results_checked);
        $display("all eight effects, ignored ids, empty ring and %0d tones dropped on a full ring",
                 tones_dropped);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/bts_pkg.sv
hdl/bts_ctrl.sv
hdl/bts_dpath.sv
hdl/buzzer_tone_sequencer_unit.sv
tb/sv/tb_buzzer_tone_sequencer_unit.sv
